@@ hw/rtl/sfb_pkg.sv @@
// shared types, constants and crc functions for the sensor frame builder
`default_nettype none

package sfb_pkg;

  localparam int MAX_BODY_BYTES_DEF  = 256;
  localparam int MAX_FRAME_BYTES_DEF = 256;
  localparam int HEADER_BYTES        = 13;
  localparam int TRAILER_BYTES       = 3;

  localparam logic [7:0]  HOP_COUNT   = 8'h01;
  localparam logic [7:0]  CRC8_POLY   = 8'h07;
  localparam logic [7:0]  CRC8_INIT   = 8'h00;
  localparam logic [15:0] CRC16_POLY  = 16'h1021;
  localparam logic [15:0] CRC16_INIT  = 16'hFFFF;

  // position of a byte within the wire frame
  typedef logic [4:0] pos_t;

  localparam pos_t POS_CMD      = 5'd0;
  localparam pos_t POS_ROUTE    = 5'd1;
  localparam pos_t POS_ID3      = 5'd2;
  localparam pos_t POS_ID2      = 5'd3;
  localparam pos_t POS_ID1      = 5'd4;
  localparam pos_t POS_ID0      = 5'd5;
  localparam pos_t POS_TID      = 5'd6;
  localparam pos_t POS_PAD1     = 5'd7;
  localparam pos_t POS_PAD0     = 5'd8;
  localparam pos_t POS_SEC3     = 5'd9;
  localparam pos_t POS_SEC2     = 5'd10;
  localparam pos_t POS_SEC1     = 5'd11;
  localparam pos_t POS_HDR_LAST = 5'd12;
  localparam pos_t POS_BODY     = 5'd13;
  localparam pos_t POS_CRC8     = 5'd14;
  localparam pos_t POS_CRC16_HI = 5'd15;
  localparam pos_t POS_CRC16_LO = 5'd16;

  typedef struct packed {
    logic       emit;
    pos_t       pos;
    logic [7:0] data;
    logic       ovf_set;
  } sfb_upd_t;

  typedef struct packed {
    logic        in_frame;
    logic        room;
    logic [7:0]  crc8;
    logic [15:0] crc16;
    logic        overflowed;
  } sfb_stat_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[7] ? ((v << 1) ^ CRC8_POLY) : (v << 1);
    end
    return v;
  endfunction

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] v;
    v = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      v = v[15] ? ((v << 1) ^ CRC16_POLY) : (v << 1);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sfb_frame_state.sv @@
// per-frame state: in-frame flag, body counter, crc accumulators, overflow flag
`default_nettype none

module sfb_frame_state #(
  parameter int MAX_BODY_BYTES  = sfb_pkg::MAX_BODY_BYTES_DEF,
  parameter int MAX_FRAME_BYTES = sfb_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire sfb_pkg::sfb_upd_t upd,
  output sfb_pkg::sfb_stat_t stat
);
  import sfb_pkg::*;

  localparam int ByFrame   = MAX_FRAME_BYTES - (HEADER_BYTES + TRAILER_BYTES);
  localparam int BodyLimit = (ByFrame < MAX_BODY_BYTES) ? ByFrame : MAX_BODY_BYTES;
  localparam int CntW      = $clog2(BodyLimit + 1);
  localparam logic [CntW-1:0] LimitC = CntW'(BodyLimit);

  logic            in_frame_r;
  logic [CntW-1:0] body_count_r;
  logic [7:0]      crc8_r;
  logic [15:0]     crc16_r;
  logic            overflowed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      body_count_r <= '0;
      crc8_r       <= CRC8_INIT;
      crc16_r      <= CRC16_INIT;
      overflowed_r <= 1'b0;
    end else begin
      if (upd.ovf_set) begin
        overflowed_r <= 1'b1;
      end
      if (upd.emit) begin
        if (upd.pos == POS_CRC16_LO) begin
          // trailer done, back to idle
          in_frame_r   <= 1'b0;
          body_count_r <= '0;
          crc8_r       <= CRC8_INIT;
          crc16_r      <= CRC16_INIT;
          overflowed_r <= 1'b0;
        end else begin
          if (upd.pos <= POS_CRC8) begin
            crc16_r <= crc16_byte(crc16_r, upd.data);
          end
          if (upd.pos == POS_CMD) begin
            in_frame_r <= 1'b1;
          end
          if (upd.pos == POS_BODY) begin
            crc8_r       <= crc8_byte(crc8_r, upd.data);
            body_count_r <= body_count_r + 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    stat.in_frame   = in_frame_r;
    stat.room       = (body_count_r < LimitC);
    stat.crc8       = crc8_r;
    stat.crc16      = crc16_r;
    stat.overflowed = overflowed_r;
  end

endmodule

`default_nettype wire

@@ hw/rtl/sensor_frame_builder_dual_crc.sv @@
// frame builder top level: item register, byte sequencer and output register
// the first byte of an item is built from the item register and then held in the output register
// throughput: one output byte per cycle while out_tready is not held low; a mid-frame body item
//   yields one byte, a first item 13 to 17 bytes, a last item 3 more; set by the single output byte register
// an item that yields no byte (dropped or absent body byte) retires without waiting for the output register
// reset: rst_n synchronous, clears valids and returns the frame state to idle
`default_nettype none

module sensor_frame_builder_dual_crc #(
  parameter int MAX_BODY_BYTES  = sfb_pkg::MAX_BODY_BYTES_DEF,
  parameter int MAX_FRAME_BYTES = sfb_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // command[7:0], agent_id[39:8], transaction_id[47:40], seconds[79:48], body_byte[87:80]
  input  wire  [87:0] in_tdata,
  input  wire         in_tuser,   // byte_present
  input  wire         in_tlast,   // frame_end
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic        out_tuser,  // frame_error
  output logic        out_tlast   // frame_last
);
  import sfb_pkg::*;

  // item register
  logic        wk_valid_r;
  logic        wk_fresh_r;
  pos_t        wk_pos_r;
  logic [7:0]  wk_cmd_r;
  logic [31:0] wk_id_r;
  logic [7:0]  wk_tid_r;
  logic [31:0] wk_sec_r;
  logic [7:0]  wk_body_r;
  logic        wk_present_r;
  logic        wk_end_r;

  // output register
  logic        out_valid_r;
  logic [7:0]  out_data_r;
  logic        out_last_r;
  logic        out_err_r;

  sfb_upd_t  upd;
  sfb_stat_t stat;

  logic       ah_vld;
  pos_t       ah_pos;
  logic       has_cur;
  pos_t       cur;
  logic       nxt_vld;
  pos_t       nxt;
  logic       can_emit;
  logic       step;
  logic       item_done;
  logic [7:0] cur_byte;

  sfb_frame_state #(
    .MAX_BODY_BYTES (MAX_BODY_BYTES),
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_state (
    .clk  (clk),
    .rst_n(rst_n),
    .upd  (upd),
    .stat (stat)
  );

  always_comb begin
    // what follows the header: body byte if it fits, else the trailer if frame ends
    ah_vld = (wk_present_r && stat.room) || wk_end_r;
    ah_pos = (wk_present_r && stat.room) ? POS_BODY : POS_CRC8;

    if (wk_fresh_r) begin
      if (!stat.in_frame) begin
        has_cur = 1'b1;
        cur     = POS_CMD;
      end else begin
        has_cur = ah_vld;
        cur     = ah_pos;
      end
    end else begin
      has_cur = 1'b1;
      cur     = wk_pos_r;
    end

    if (cur < POS_HDR_LAST) begin
      nxt_vld = 1'b1;
      nxt     = cur + 5'd1;
    end else if (cur == POS_HDR_LAST) begin
      nxt_vld = ah_vld;
      nxt     = ah_pos;
    end else if (cur == POS_BODY) begin
      nxt_vld = wk_end_r;
      nxt     = POS_CRC8;
    end else if (cur == POS_CRC8) begin
      nxt_vld = 1'b1;
      nxt     = POS_CRC16_HI;
    end else if (cur == POS_CRC16_HI) begin
      nxt_vld = 1'b1;
      nxt     = POS_CRC16_LO;
    end else begin
      nxt_vld = 1'b0;
      nxt     = POS_CMD;
    end

    can_emit  = !out_valid_r || out_tready;
    step      = wk_valid_r && (has_cur ? can_emit : 1'b1);
    item_done = step && (!has_cur || !nxt_vld);
    in_tready = !wk_valid_r || item_done;

    case (cur)
      POS_CMD:      cur_byte = wk_cmd_r;
      POS_ROUTE:    cur_byte = HOP_COUNT;
      POS_ID3:      cur_byte = wk_id_r[31:24];
      POS_ID2:      cur_byte = wk_id_r[23:16];
      POS_ID1:      cur_byte = wk_id_r[15:8];
      POS_ID0:      cur_byte = wk_id_r[7:0];
      POS_TID:      cur_byte = wk_tid_r;
      POS_PAD1:     cur_byte = 8'h00;
      POS_PAD0:     cur_byte = 8'h00;
      POS_SEC3:     cur_byte = wk_sec_r[31:24];
      POS_SEC2:     cur_byte = wk_sec_r[23:16];
      POS_SEC1:     cur_byte = wk_sec_r[15:8];
      POS_HDR_LAST: cur_byte = wk_sec_r[7:0];
      POS_BODY:     cur_byte = wk_body_r;
      POS_CRC8:     cur_byte = stat.crc8;
      POS_CRC16_HI: cur_byte = stat.crc16[15:8];
      POS_CRC16_LO: cur_byte = stat.crc16[7:0];
      default:      cur_byte = 8'h00;
    endcase

    upd.emit    = step && has_cur;
    upd.pos     = cur;
    upd.data    = cur_byte;
    // a present byte with no room left is dropped where the body decision is made
    upd.ovf_set = step && wk_present_r && !stat.room &&
                  ((wk_fresh_r && stat.in_frame) || (has_cur && cur == POS_HDR_LAST));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wk_valid_r <= 1'b0;
      wk_fresh_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      wk_valid_r <= 1'b1;
      wk_fresh_r <= 1'b1;
    end else if (item_done) begin
      wk_valid_r <= 1'b0;
    end else if (step) begin
      wk_fresh_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      wk_cmd_r     <= in_tdata[7:0];
      wk_id_r      <= in_tdata[39:8];
      wk_tid_r     <= in_tdata[47:40];
      wk_sec_r     <= in_tdata[79:48];
      wk_body_r    <= in_tdata[87:80];
      wk_present_r <= in_tuser;
      wk_end_r     <= in_tlast;
    end
    if (step && nxt_vld) begin
      wk_pos_r <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.emit) begin
      out_data_r <= cur_byte;
      out_last_r <= (cur == POS_CRC16_LO);
      out_err_r  <= (cur == POS_CRC16_LO) && stat.overflowed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

endmodule

`default_nettype wire
